// ===== src/slev_pkg.sv =====
// Shared types and constants for the sprite line evaluation unit.
package slev_pkg;

	localparam int ADDR_W = 4;

	// Register index codes (byte address = 4 * index)
	typedef enum logic [1:0] {
		REG_TALL     = 2'd0,
		REG_ZOOM     = 2'd1,
		REG_EXTENDED = 2'd2,
		REG_NO_LIMIT = 2'd3
	} slev_reg_t;

	localparam logic [7:0] END_MARK    = 8'd208;
	localparam logic [7:0] WRAP_ABOVE  = 8'd240;
	localparam logic [5:0] BASE_HEIGHT = 6'd8;
	localparam logic [6:0] FOUND_MAX   = 7'h7F;

	typedef struct packed {
		logic tall;
		logic zoomed;
		logic extended;
		logic no_limit;
	} slev_cfg_t;

	typedef struct packed {
		logic       first_of_line;
		logic [7:0] line_count;
		logic       on_active_line;
		logic [7:0] sprite_y;
		logic [7:0] sprite_x;
		logic [7:0] sprite_pattern;
	} slev_entry_t;

	typedef struct packed {
		logic       selected;
		logic [5:0] slot;
		logic [4:0] row_in_sprite;
		logic [7:0] out_x;
		logic [7:0] out_pattern;
		logic       overflow;
		logic       scan_stopped;
	} slev_res_t;

endpackage

// ===== src/slev_stream_if.sv =====
// Valid/ready stream interface carrying one payload struct.
interface slev_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== src/slev_cfg.sv =====
// APB-style configuration registers.
module slev_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [slev_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output slev_pkg::slev_cfg_t       cfg
);
	import slev_pkg::*;

	slev_cfg_t cfg_q;
	slev_reg_t reg_sel;
	logic      wr_en;

	assign reg_sel = slev_reg_t'(paddr[3:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_TALL:     cfg_q.tall     <= pwdata[0];
				REG_ZOOM:     cfg_q.zoomed   <= pwdata[0];
				REG_EXTENDED: cfg_q.extended <= pwdata[0];
				REG_NO_LIMIT: cfg_q.no_limit <= pwdata[0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_TALL:     prdata[0] = cfg_q.tall;
			REG_ZOOM:     prdata[0] = cfg_q.zoomed;
			REG_EXTENDED: prdata[0] = cfg_q.extended;
			REG_NO_LIMIT: prdata[0] = cfg_q.no_limit;
			default:      prdata    = '0;
		endcase
	end
endmodule

// ===== src/slev_eval.sv =====
// Per-entry sprite range test and line state (found count, stop flag, entry count).
module slev_eval #(
	parameter int TABLE_ENTRIES = 64,
	parameter int LINE_LIMIT    = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  slev_pkg::slev_cfg_t   cfg,
	input  slev_pkg::slev_entry_t ent,
	output slev_pkg::slev_res_t   res
);
	import slev_pkg::*;

	localparam int SEEN_W = $clog2(TABLE_ENTRIES + 1);

	logic [6:0]        found_q, found0, found_d;
	logic              stopped_q, stopped0, stopped_d;
	logic [SEEN_W-1:0] seen_q, seen0, seen_d;
	logic              table_done, end_mark, active_scan;
	logic [8:0]        y_wrap;
	logic [9:0]        diff;
	logic [5:0]        height;
	logic              hit, at_limit, take, limit_stop;

	always_comb begin
		found0   = ent.first_of_line ? '0 : found_q;
		stopped0 = ent.first_of_line ? 1'b0 : stopped_q;
		seen0    = ent.first_of_line ? '0 : seen_q;

		table_done = seen0 >= SEEN_W'(TABLE_ENTRIES);
		seen_d     = table_done ? seen0 : seen0 + SEEN_W'(1);

		// Y above 240 is a sprite partly above the top edge: take as Y - 256
		y_wrap = {(ent.sprite_y > WRAP_ABOVE), ent.sprite_y};
		diff   = {2'b00, ent.line_count} - {y_wrap[8], y_wrap};
		height = BASE_HEIGHT << {cfg.tall & cfg.zoomed, cfg.tall ^ cfg.zoomed};

		active_scan = !(stopped0 || table_done);
		end_mark    = !cfg.extended && (ent.sprite_y == END_MARK);
		hit         = active_scan && !end_mark && !diff[9] && (diff < {4'b0, height});
		at_limit    = found0 == 7'(LINE_LIMIT);
		limit_stop  = hit && at_limit && !cfg.no_limit;
		take        = hit && !limit_stop;

		stopped_d = stopped0 || table_done || (active_scan && end_mark) || limit_stop;
		found_d   = (take && found0 != FOUND_MAX) ? found0 + 7'd1 : found0;

		res.selected      = take;
		res.slot          = take ? found0[5:0] : '0;
		res.row_in_sprite = take ? diff[4:0] : '0;
		res.out_x         = take ? ent.sprite_x : '0;
		res.out_pattern   = take ? ent.sprite_pattern : '0;
		res.overflow      = hit && at_limit && ent.on_active_line;
		res.scan_stopped  = stopped_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= '0;
			stopped_q <= 1'b0;
			seen_q    <= '0;
		end else if (fire) begin
			found_q   <= found_d;
			stopped_q <= stopped_d;
			seen_q    <= seen_d;
		end
	end

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= SEEN_W'(TABLE_ENTRIES))
		else $error("entry count past table size");

	a_limit_stops: assert property (@(posedge clk) disable iff (!arst_n)
		fire && limit_stop |=> stopped_q && found_q == $past(found0))
		else $error("limit hit did not stop the scan");

	a_stopped_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q && !(fire && ent.first_of_line) |=> stopped_q)
		else $error("stop flag dropped within a line");
endmodule

// ===== src/sprite_line_evaluation_unit.sv =====
// Top level of the sprite line evaluation unit: input register, evaluation, result register.
//
//  channel   dir  protocol      payload
//  entry     in   valid/ready   slev_entry_t  (one sprite-table entry + line info)
//  result    out  valid/ready   slev_res_t    (one result per entry)
//  apb       in   APB write/rd  four 1-bit mode registers at 0x0, 0x4, 0x8, 0xC
//
// A request is registered in s1, evaluated, and its result is registered in s2,
// where it can be taken; one request is taken every cycle while result is not
// stalled, set by the single evaluation stage between s1 and s2.
// The line state (found count, stop flag, entry count) advances as a request
// leaves s1, so back-to-back requests see each other's effects.
// A stall on result holds s2 and s1; entry.ready falls only when both are full.
// arst_n clears the valids, the line state and the mode registers.
module sprite_line_evaluation_unit #(
	parameter int TABLE_ENTRIES = 64,
	parameter int LINE_LIMIT    = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	slev_stream_if.sink                 entry,
	slev_stream_if.source               result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [slev_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import slev_pkg::*;

	slev_cfg_t   cfg;
	slev_entry_t entry_s1;
	logic        valid_s1;
	slev_res_t   res_eval;
	slev_res_t   res_s2;
	logic        valid_s2;
	logic        adv;

	slev_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// s1 moves on when s2 is empty or being drained this cycle
	assign adv         = valid_s1 && (!valid_s2 || result.ready);
	assign entry.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (entry.ready) begin
			valid_s1 <= entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (entry.valid && entry.ready) begin
			entry_s1 <= entry.payload;
		end
	end

	slev_eval #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.LINE_LIMIT    (LINE_LIMIT)
	) u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.cfg    (cfg),
		.ent    (entry_s1),
		.res    (res_eval)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_eval;
		end
	end

	assign result.valid   = valid_s2;
	assign result.payload = res_s2;

	// a stored sprite never comes with a stopped scan
	a_sel_not_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.selected |-> !res_s2.scan_stopped)
		else $error("selected result reports stopped scan");

	// a request in s1 is never dropped while s2 is stalled
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !result.ready |=> valid_s1 && $stable(entry_s1))
		else $error("s1 request lost under stall");
endmodule

// ===== tb/sv/tb_sprite_line_evaluation_unit.sv =====
// Self-checking testbench for the sprite line evaluation unit.
module tb_sprite_line_evaluation_unit;
	import slev_pkg::*;

	localparam int TABLE_ENTRIES = 64;
	localparam int LINE_LIMIT    = 8;
	localparam int ITEMS         = 1000;    // requests in the random part
	localparam int PHASE_ITEMS   = 100;     // requests per mode setting
	localparam int CYCLE_LIMIT   = 500000;
	localparam int DIRECTED_ROWS = 23;

	// Mode words, bits ordered tall, zoomed, extended, no_limit
	localparam slev_cfg_t MODE_RESET     = 4'b0000;
	localparam slev_cfg_t MODE_TALL      = 4'b1000;
	localparam slev_cfg_t MODE_TALL_ZOOM = 4'b1100;
	localparam slev_cfg_t MODE_EXTENDED  = 4'b0010;
	localparam slev_cfg_t MODE_ALL       = 4'b1111;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	slev_stream_if #(.payload_t(slev_entry_t)) entry_if ();
	slev_stream_if #(.payload_t(slev_res_t))   result_if ();

	sprite_line_evaluation_unit #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.LINE_LIMIT(LINE_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.entry(entry_if),
		.result(result_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Line evaluation predictor: own copy of the mode registers and of
	// the per-line state, advanced once per accepted request.
	// ------------------------------------------------------------------
	slev_cfg_t   mode_regs     = MODE_RESET;
	logic [6:0]  found_count   = '0;
	logic        line_stopped  = 1'b0;
	int          entries_seen  = 0;
	slev_res_t   expected_results [$];    // evaluation results still to come out
	int          error_count   = 0;

	function automatic slev_res_t predict_entry(slev_entry_t req);
		slev_res_t r;
		int        top;
		int        diff;
		int        height;
		r = '0;
		if (req.first_of_line) begin
			found_count  = '0;
			line_stopped = 1'b0;
			entries_seen = 0;
		end
		// entries beyond the table size behave as a stopped scan
		if (entries_seen >= TABLE_ENTRIES)
			line_stopped = 1'b1;
		else
			entries_seen++;
		if (!line_stopped) begin
			if (!mode_regs.extended && req.sprite_y == END_MARK) begin
				line_stopped = 1'b1;
			end else begin
				top = int'(req.sprite_y);
				if (top > int'(WRAP_ABOVE))
					top -= 256;     // sprites partly above the top edge
				diff   = int'(req.line_count) - top;
				height = int'(BASE_HEIGHT);
				if (mode_regs.tall)
					height *= 2;
				if (mode_regs.zoomed)
					height *= 2;
				if (diff >= 0 && diff < height) begin
					if (found_count == LINE_LIMIT) begin
						r.overflow = req.on_active_line;
						if (!mode_regs.no_limit)
							line_stopped = 1'b1;
					end
					if (!line_stopped) begin
						r.selected      = 1'b1;
						r.slot          = found_count[5:0];
						r.row_in_sprite = diff[4:0];
						r.out_x         = req.sprite_x;
						r.out_pattern   = req.sprite_pattern;
						if (found_count != FOUND_MAX)
							found_count++;
					end
				end
			end
		end
		r.scan_stopped = line_stopped;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	function automatic void check_result(slev_res_t got);
		slev_res_t want;
		if (expected_results.size() == 0) begin
			$error("result arrived with no request outstanding");
			error_count++;
			return;
		end
		want = expected_results.pop_front();
		compare_field("selected", 8'(want.selected), 8'(got.selected));
		compare_field("slot", 8'(want.slot), 8'(got.slot));
		compare_field("row_in_sprite", 8'(want.row_in_sprite), 8'(got.row_in_sprite));
		compare_field("out_x", want.out_x, got.out_x);
		compare_field("out_pattern", want.out_pattern, got.out_pattern);
		compare_field("overflow", 8'(want.overflow), 8'(got.overflow));
		compare_field("scan_stopped", 8'(want.scan_stopped), 8'(got.scan_stopped));
	endfunction

	// Idle length: mostly none, some short, a few long; none at all when calm
	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// ------------------------------------------------------------------
	// Request driver. Valid stays high across back-to-back requests;
	// prediction happens at the edge where the request is taken.
	// ------------------------------------------------------------------
	task automatic send_request(input slev_entry_t req, input int gap, input bit typed,
			input slev_res_t want);
		slev_res_t predicted;
		if (gap > 0) begin
			entry_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		entry_if.valid   <= 1'b1;
		entry_if.payload <= req;
		do @(posedge clk); while (entry_if.ready !== 1'b1);
		predicted = predict_entry(req);
		// hand-typed expectations take the place of the prediction
		expected_results.push_back(typed ? want : predicted);
	endtask

	// APB write followed by a read back of the same register
	task automatic write_register(slev_reg_t idx, logic value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {31'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== {31'd0, value}) begin
			$error("prdata of %s: expected %0h, got %0h", idx.name(), {31'd0, value}, prdata);
			error_count++;
		end
	endtask

	// Mode change only with the pipeline empty
	task automatic apply_mode(slev_cfg_t m);
		entry_if.valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (2) @(posedge clk);
		write_register(REG_TALL, m.tall);
		write_register(REG_ZOOM, m.zoomed);
		write_register(REG_EXTENDED, m.extended);
		write_register(REG_NO_LIMIT, m.no_limit);
		psel    <= 1'b0;
		penable <= 1'b0;
		mode_regs = m;
	endtask

	// ------------------------------------------------------------------
	// Directed table. Rows with typed = 1 carry the result by hand, the
	// rest are predicted. Entry: first, line, active, y, x, pattern.
	// Result: selected, slot, row, x, pattern, overflow, stopped.
	// ------------------------------------------------------------------
	typedef struct {
		slev_cfg_t   mode;
		slev_entry_t req;
		bit          typed;
		slev_res_t   want;
	} directed_row_t;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		// top row of a sprite, x and pattern at their maximum
		'{MODE_RESET, '{1'b1, 8'd10, 1'b1, 8'd10, 8'd255, 8'd255}, 1'b1,
			'{1'b1, 6'd0, 5'd0, 8'd255, 8'd255, 1'b0, 1'b0}},
		// bottom row of an 8-line sprite
		'{MODE_RESET, '{1'b0, 8'd10, 1'b1, 8'd3, 8'd0, 8'd0}, 1'b1,
			'{1'b1, 6'd1, 5'd7, 8'd0, 8'd0, 1'b0, 1'b0}},
		// one line below the sprite: not selected, outputs zeroed
		'{MODE_RESET, '{1'b0, 8'd10, 1'b1, 8'd2, 8'h12, 8'h34}, 1'b1, '0},
		// one line above the sprite
		'{MODE_RESET, '{1'b0, 8'd10, 1'b1, 8'd11, 8'h12, 8'h34}, 1'b1, '0},
		// end-of-list marker stops the scan
		'{MODE_RESET, '{1'b0, 8'd10, 1'b1, END_MARK, 8'h56, 8'h78}, 1'b1,
			'{1'b0, 6'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b1}},
		// hit after the stop is ignored
		'{MODE_RESET, '{1'b0, 8'd10, 1'b1, 8'd10, 8'h56, 8'h78}, 1'b1,
			'{1'b0, 6'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b1}},
		// Y above 240 wraps negative: 250 covers line 0 at row 6
		'{MODE_RESET, '{1'b1, 8'd0, 1'b1, 8'd250, 8'h55, 8'hAA}, 1'b1,
			'{1'b1, 6'd0, 5'd6, 8'h55, 8'hAA, 1'b0, 1'b0}},
		'{MODE_RESET, '{1'b0, 8'd0, 1'b1, 8'd241, 8'h55, 8'hAA}, 1'b1, '0},
		'{MODE_RESET, '{1'b0, 8'd0, 1'b1, WRAP_ABOVE, 8'h55, 8'hAA}, 1'b1, '0},
		// eight hits fill the line, the ninth overflows and stops
		'{MODE_RESET, '{1'b1, 8'd100, 1'b1, 8'd100, 8'd0, 8'd0}, 1'b1,
			'{1'b1, 6'd0, 5'd0, 8'd0, 8'd0, 1'b0, 1'b0}},
		'{MODE_RESET, '{1'b0, 8'd100, 1'b1, 8'd99, 8'd1, 8'd1}, 1'b1,
			'{1'b1, 6'd1, 5'd1, 8'd1, 8'd1, 1'b0, 1'b0}},
		'{MODE_RESET, '{1'b0, 8'd100, 1'b1, 8'd98, 8'd2, 8'd2}, 1'b1,
			'{1'b1, 6'd2, 5'd2, 8'd2, 8'd2, 1'b0, 1'b0}},
		'{MODE_RESET, '{1'b0, 8'd100, 1'b1, 8'd97, 8'd3, 8'd3}, 1'b1,
			'{1'b1, 6'd3, 5'd3, 8'd3, 8'd3, 1'b0, 1'b0}},
		'{MODE_RESET, '{1'b0, 8'd100, 1'b1, 8'd96, 8'd4, 8'd4}, 1'b1,
			'{1'b1, 6'd4, 5'd4, 8'd4, 8'd4, 1'b0, 1'b0}},
		'{MODE_RESET, '{1'b0, 8'd100, 1'b1, 8'd95, 8'd5, 8'd5}, 1'b1,
			'{1'b1, 6'd5, 5'd5, 8'd5, 8'd5, 1'b0, 1'b0}},
		'{MODE_RESET, '{1'b0, 8'd100, 1'b1, 8'd94, 8'd6, 8'd6}, 1'b1,
			'{1'b1, 6'd6, 5'd6, 8'd6, 8'd6, 1'b0, 1'b0}},
		'{MODE_RESET, '{1'b0, 8'd100, 1'b1, 8'd93, 8'd7, 8'd7}, 1'b1,
			'{1'b1, 6'd7, 5'd7, 8'd7, 8'd7, 1'b0, 1'b0}},
		'{MODE_RESET, '{1'b0, 8'd100, 1'b1, 8'd93, 8'd8, 8'd8}, 1'b1,
			'{1'b0, 6'd0, 5'd0, 8'd0, 8'd0, 1'b1, 1'b1}},
		// tall sprite, row 15 on a blanked line
		'{MODE_TALL, '{1'b1, 8'd20, 1'b0, 8'd5, 8'h9C, 8'h3E}, 1'b0, '0},
		// tall and zoomed, row 31
		'{MODE_TALL_ZOOM, '{1'b1, 8'd40, 1'b1, 8'd9, 8'h81, 8'h80}, 1'b0, '0},
		// extended mode: 208 is an ordinary Y
		'{MODE_EXTENDED, '{1'b1, 8'd210, 1'b1, END_MARK, 8'h0F, 8'hF0}, 1'b0, '0},
		// every mode bit set, last line
		'{MODE_ALL, '{1'b1, 8'd255, 1'b1, 8'd224, 8'hFF, 8'h00}, 1'b0, '0},
		'{MODE_ALL, '{1'b0, 8'd255, 1'b1, 8'd255, 8'h00, 8'hFF}, 1'b0, '0}
	};

	// ------------------------------------------------------------------
	// Stimulus: reset, directed table, then random sprite-table lines
	// under a sequence of mode settings.
	// ------------------------------------------------------------------
	initial begin : stimulus
		slev_entry_t e;
		slev_cfg_t   m;
		bit          tx_calm;
		logic [7:0]  line;
		logic        active;
		int          i;
		int          k;
		int          len;
		int          pick;
		int          height;
		int          phase;
		int          counted;
		int          phase_counted;

		arst_n           <= 1'b0;
		entry_if.valid   <= 1'b0;
		entry_if.payload <= '0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_rows[i].mode != mode_regs)
				apply_mode(directed_rows[i].mode);
			send_request(directed_rows[i].req, pick_gap(1'b0), directed_rows[i].typed,
				directed_rows[i].want);
		end

		// Random part: first phase at reset mode, second with every bit set, later ones random
		phase   = 0;
		counted = 0;
		while (counted < ITEMS) begin
			case (phase)
				0: m = MODE_RESET;
				1: m = MODE_ALL;
				default: m = slev_cfg_t'(4'($urandom_range(0, 15)));
			endcase
			apply_mode(m);
			height = int'(BASE_HEIGHT);
			if (m.tall)
				height *= 2;
			if (m.zoomed)
				height *= 2;
			phase_counted = 0;
			while (phase_counted < PHASE_ITEMS) begin
				line    = 8'($urandom);
				active  = ($urandom_range(0, 4) != 0);
				tx_calm = ($urandom_range(0, 5) == 0);
				// now and then a line around or beyond the sprite table's length
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 72)
					: $urandom_range(1, 20);
				for (k = 0; k < len; k++) begin
					e.first_of_line  = (k == 0);
					e.line_count     = line;
					e.on_active_line = active;
					pick = $urandom_range(0, 99);
					if (pick < 55)          // in or just around the sprite's rows
						e.sprite_y = line - 8'($urandom_range(0, height + 1));
					else if (pick < 59)
						e.sprite_y = END_MARK;
					else if (pick < 67)     // wrapped Y range
						e.sprite_y = 8'($urandom_range(241, 255));
					else
						e.sprite_y = 8'($urandom);
					e.sprite_x       = 8'($urandom);
					e.sprite_pattern = 8'($urandom);
					// broken sequences: stray line start or line fields
					if ($urandom_range(0, 19) == 0) begin
						e.first_of_line  = 1'($urandom);
						e.line_count     = 8'($urandom);
						e.on_active_line = 1'($urandom);
					end
					send_request(e, pick_gap(tx_calm), 1'b0, '0);
					phase_counted++;
				end
			end
			counted += phase_counted;
			phase++;
		end

		entry_if.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("tb_sprite_line_evaluation_unit OK");
		else
			$display("tb_sprite_line_evaluation_unit NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result sink: random stalls, calm stretches, and one long hold-off
	// while requests are on offer so that both stages fill and
	// entry.ready drops.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int stall_left;
		int results_checked;
		bit rx_calm;
		bit held_off;
		stall_left      = 0;
		results_checked = 0;
		rx_calm         = 1'b0;
		held_off        = 1'b0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
				check_result(result_if.payload);
				results_checked++;
				if ($urandom_range(0, 63) == 0)
					rx_calm = !rx_calm;
			end
			if (!held_off && results_checked >= 300 && entry_if.valid === 1'b1) begin
				stall_left = 400;
				held_off   = 1'b1;
			end
			if (stall_left > 0) begin
				result_if.ready <= 1'b0;
				stall_left--;
			end else begin
				result_if.ready <= 1'b1;
				stall_left = pick_gap(rx_calm);
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_sprite_line_evaluation_unit NOT OK");
		$finish;
	end

endmodule
